// ===== hdl/bhc_pkg.sv =====
package bhc_pkg;

    localparam int SYMBOL_COUNT = 256;
    localparam int SYM_W        = $clog2(SYMBOL_COUNT);
    localparam int NODE_SLOTS   = 2 * SYMBOL_COUNT;
    localparam int NODE_W       = $clog2(NODE_SLOTS);
    localparam int COUNT_W      = 16;
    localparam int WEIGHT_W     = COUNT_W + SYM_W;
    localparam int CODE_W       = 16;
    localparam int LEN_W        = 8;
    localparam int CODE_IDX_W   = $clog2(CODE_W);

    localparam logic [NODE_W-1:0]  ROOT_NODE = NODE_W'(NODE_SLOTS - 2);
    localparam logic [SYM_W-1:0]   LAST_SYM  = SYM_W'(SYMBOL_COUNT - 1);
    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    localparam logic [1:0] FUNC_COUNT  = 2'd0;
    localparam logic [1:0] FUNC_BUILD  = 2'd1;
    localparam logic [1:0] FUNC_ENCODE = 2'd2;
    localparam logic [1:0] FUNC_DECODE = 2'd3;

    localparam logic [1:0] KIND_CODE   = 2'd0;
    localparam logic [1:0] KIND_SYMBOL = 2'd1;
    localparam logic [1:0] KIND_BUILD  = 2'd2;

    typedef struct packed {
        logic [1:0]       func;
        logic [SYM_W-1:0] data_byte;
        logic             code_bit;
    } item_t;

    typedef struct packed {
        logic [1:0]        kind;
        logic [CODE_W-1:0] code_word;
        logic [LEN_W-1:0]  code_length;
        logic [SYM_W-1:0]  symbol;
        logic              too_long;
    } result_t;

    typedef struct packed {
        logic [NODE_W-1:0]   node;
        logic [WEIGHT_W-1:0] weight;
    } entry_t;

    typedef struct packed {
        logic [NODE_W-1:0] one;
        logic [NODE_W-1:0] zero;
    } link_t;

    typedef struct packed {
        logic   clear;
        logic   insert;
        logic   pop;
        entry_t entry;
    } lst_req_t;

    typedef struct packed {
        logic   done;
        logic   multi;
        entry_t first;
        entry_t second;
    } lst_rsp_t;

    typedef enum logic [2:0] {
        L_IDLE,
        L_SCAN,
        L_HEAD,
        L_POP0,
        L_POP1
    } lst_state_t;

    typedef enum logic [3:0] {
        T_IDLE,
        T_EXEC,
        T_HOLD,
        B_HIST_RD,
        B_HIST_INS,
        B_INS_WAIT,
        B_POP,
        B_POP_WAIT,
        B_LINK,
        B_LINK2,
        B_MRG_WAIT,
        W_START,
        W_STEP,
        B_DONE
    } top_state_t;

endpackage

// ===== hdl/bhc_sort_list.sv =====
// Sorted list of (node, weight) entries held in a memory window [head, tail).
// Insertion scans backward from the tail, shifting one entry per cycle.
module bhc_sort_list import bhc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  lst_req_t req,
    output lst_rsp_t rsp
);

    entry_t list_mem [NODE_SLOTS];

    lst_state_t        state_reg, state_next;
    logic [NODE_W-1:0] head_reg, head_next;
    logic [NODE_W-1:0] tail_reg, tail_next;
    logic [NODE_W-1:0] p_reg, p_next;
    entry_t            ent_reg, ent_next;
    entry_t            first_reg, first_next;
    entry_t            second_reg, second_next;
    logic              done_reg, done_next;
    entry_t            rd_data_reg;

    logic              rd_en;
    logic [NODE_W-1:0] rd_addr;
    logic              wr_en;
    logic [NODE_W-1:0] wr_addr;
    entry_t            wr_data;
    logic              at_head;
    logic              shift;

    assign at_head = (p_reg == head_reg);
    assign shift   = at_head ? (ent_reg.weight < rd_data_reg.weight)
                             : (rd_data_reg.weight >= ent_reg.weight);

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            list_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= list_mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= L_IDLE;
            head_reg  <= '0;
            tail_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        p_reg      <= p_next;
        ent_reg    <= ent_next;
        first_reg  <= first_next;
        second_reg <= second_next;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            L_IDLE:
            begin
                if (req.clear)
                begin
                    state_next = L_IDLE;
                end
                else if (req.pop)
                begin
                    state_next = L_POP0;
                end
                else if (req.insert && (head_reg != tail_reg))
                begin
                    state_next = L_SCAN;
                end
            end
            L_SCAN:
            begin
                if (!shift)
                begin
                    state_next = L_IDLE;
                end
                else if (at_head)
                begin
                    state_next = L_HEAD;
                end
            end
            L_HEAD:  state_next = L_IDLE;
            L_POP0:  state_next = L_POP1;
            L_POP1:  state_next = L_IDLE;
            default: state_next = L_IDLE;
        endcase
    end

    always_comb
    begin
        head_next   = head_reg;
        tail_next   = tail_reg;
        p_next      = p_reg;
        ent_next    = ent_reg;
        first_next  = first_reg;
        second_next = second_reg;
        done_next   = 1'b0;
        rd_en       = 1'b0;
        rd_addr     = p_reg;
        wr_en       = 1'b0;
        wr_addr     = p_reg;
        wr_data     = ent_reg;
        case (state_reg)
            L_IDLE:
            begin
                if (req.clear)
                begin
                    head_next = '0;
                    tail_next = '0;
                end
                else if (req.pop)
                begin
                    rd_en   = 1'b1;
                    rd_addr = head_reg;
                end
                else if (req.insert)
                begin
                    ent_next = req.entry;
                    if (head_reg == tail_reg)
                    begin
                        wr_en     = 1'b1;
                        wr_addr   = tail_reg;
                        wr_data   = req.entry;
                        tail_next = tail_reg + NODE_W'(1);
                        done_next = 1'b1;
                    end
                    else
                    begin
                        rd_en   = 1'b1;
                        rd_addr = tail_reg - NODE_W'(1);
                        p_next  = tail_reg - NODE_W'(1);
                    end
                end
            end
            L_SCAN:
            begin
                wr_en   = 1'b1;
                wr_addr = p_reg + NODE_W'(1);
                if (shift)
                begin
                    wr_data = rd_data_reg;
                    if (!at_head)
                    begin
                        rd_en   = 1'b1;
                        rd_addr = p_reg - NODE_W'(1);
                        p_next  = p_reg - NODE_W'(1);
                    end
                end
                else
                begin
                    wr_data   = ent_reg;
                    tail_next = tail_reg + NODE_W'(1);
                    done_next = 1'b1;
                end
            end
            L_HEAD:
            begin
                wr_en     = 1'b1;
                wr_addr   = head_reg;
                wr_data   = ent_reg;
                tail_next = tail_reg + NODE_W'(1);
                done_next = 1'b1;
            end
            L_POP0:
            begin
                first_next = rd_data_reg;
                rd_en      = 1'b1;
                rd_addr    = head_reg + NODE_W'(1);
            end
            L_POP1:
            begin
                second_next = rd_data_reg;
                head_next   = head_reg + NODE_W'(2);
                done_next   = 1'b1;
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    assign rsp.done   = done_reg;
    assign rsp.multi  = ((tail_reg - head_reg) > NODE_W'(1));
    assign rsp.first  = first_reg;
    assign rsp.second = second_reg;

endmodule

// ===== hdl/byte_huffman_codec.sv =====
// Count, encode and decode transactions issue the memory read at acceptance; the read data
// is registered, and the result loads in T_EXEC, or in T_HOLD while the result slot is full.
// No new item is accepted until the block is back in T_IDLE. A build fills the sorted list
// one insert per symbol, merges 255 times, then walks each leaf up at one cycle per level.
// Reset clears control state, the histogram valid bits and the built flag; decoding restarts
// at the root. Node and list memories need no clearing: a build writes them before use.
module byte_huffman_codec import bhc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    item_valid,
    output logic    item_stall,
    input  item_t   item,
    output logic    result_valid,
    input  logic    result_stall,
    output result_t result
);

    // Histogram counts; an entry whose valid bit is clear reads as zero, so a build
    // clears the whole histogram at once by dropping the valid bits.
    logic [COUNT_W-1:0]       hist_mem [SYMBOL_COUNT];
    // Code table entry: length in the upper byte, code bits below.
    logic [LEN_W+CODE_W-1:0]  code_mem [SYMBOL_COUNT];
    // Child links of internal nodes, and the parent link of every node but the root.
    link_t                    link_mem [NODE_SLOTS];
    logic [NODE_W-1:0]        up_mem   [NODE_SLOTS];

    top_state_t               state_reg, state_next;
    logic [SYMBOL_COUNT-1:0]  hist_vld_reg, hist_vld_next;
    logic                     built_reg, built_next;
    logic [NODE_W-1:0]        pos_reg, pos_next;
    logic                     res_valid_reg, res_valid_next;
    result_t                  res_reg, res_next;
    result_t                  pend_reg, pend_next;
    item_t                    in_reg, in_next;
    logic [SYM_W-1:0]         s_reg, s_next;
    logic [NODE_W-1:0]        next_reg, next_next;
    logic [NODE_W-1:0]        node_reg, node_next;
    logic [NODE_W-1:0]        prev_reg, prev_next;
    logic [LEN_W-1:0]         k_reg, k_next;
    logic [CODE_W-1:0]        code_reg, code_next;

    logic                     hist_rd_en, hist_wr_en;
    logic [SYM_W-1:0]         hist_rd_addr, hist_wr_addr;
    logic [COUNT_W-1:0]       hist_wr_data, hist_rd_data;
    logic                     code_rd_en, code_wr_en;
    logic [SYM_W-1:0]         code_rd_addr, code_wr_addr;
    logic [LEN_W+CODE_W-1:0]  code_wr_data, code_rd_data;
    logic                     link_rd_en, link_wr_en;
    logic [NODE_W-1:0]        link_rd_addr, link_wr_addr;
    link_t                    link_wr_data, link_rd_data;
    logic                     up_rd_en, up_wr_en;
    logic [NODE_W-1:0]        up_rd_addr, up_wr_addr, up_wr_data, up_rd_data;

    lst_req_t                 lst_req;
    lst_rsp_t                 lst_rsp;

    logic                     accept;
    logic                     slot_free;
    logic                     exec_has_res;
    result_t                  exec_res;
    result_t                  build_res;
    logic [NODE_W-1:0]        dec_next;
    logic [COUNT_W-1:0]       hist_cur;
    logic [LEN_W-1:0]         enc_len;
    logic [LEN_W-1:0]         edge_idx;
    logic [CODE_W-1:0]        code_upd;

    bhc_sort_list u_list
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (lst_req),
        .rsp   (lst_rsp)
    );

    // The block works on one transaction at a time; the result register lets the
    // next transaction start while a result still waits downstream.
    assign item_stall   = (state_reg != T_IDLE);
    assign accept       = item_valid && !item_stall;
    assign result_valid = res_valid_reg;
    assign result       = res_reg;
    assign slot_free    = !res_valid_reg || !result_stall;

    always_ff @(posedge clk)
    begin
        if (hist_wr_en)
        begin
            hist_mem[hist_wr_addr] <= hist_wr_data;
        end
        if (hist_rd_en)
        begin
            hist_rd_data <= hist_mem[hist_rd_addr];
        end
        if (code_wr_en)
        begin
            code_mem[code_wr_addr] <= code_wr_data;
        end
        if (code_rd_en)
        begin
            code_rd_data <= code_mem[code_rd_addr];
        end
        if (link_wr_en)
        begin
            link_mem[link_wr_addr] <= link_wr_data;
        end
        if (link_rd_en)
        begin
            link_rd_data <= link_mem[link_rd_addr];
        end
        if (up_wr_en)
        begin
            up_mem[up_wr_addr] <= up_wr_data;
        end
        if (up_rd_en)
        begin
            up_rd_data <= up_mem[up_rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= T_IDLE;
            hist_vld_reg  <= '0;
            built_reg     <= 1'b0;
            pos_reg       <= ROOT_NODE;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            hist_vld_reg  <= hist_vld_next;
            built_reg     <= built_next;
            pos_reg       <= pos_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg  <= res_next;
        pend_reg <= pend_next;
        in_reg   <= in_next;
        s_reg    <= s_next;
        next_reg <= next_next;
        node_reg <= node_next;
        prev_reg <= prev_next;
        k_reg    <= k_next;
        code_reg <= code_next;
    end

    // Results of count, encode and decode transactions, formed from the read data.
    always_comb
    begin
        hist_cur     = hist_vld_reg[in_reg.data_byte] ? hist_rd_data : '0;
        enc_len      = built_reg ? code_rd_data[LEN_W+CODE_W-1:CODE_W] : '0;
        dec_next     = in_reg.code_bit ? link_rd_data.one : link_rd_data.zero;
        exec_res     = '0;
        exec_has_res = 1'b0;
        case (in_reg.func)
            FUNC_ENCODE:
            begin
                exec_has_res         = 1'b1;
                exec_res.kind        = KIND_CODE;
                exec_res.code_word   = built_reg ? code_rd_data[CODE_W-1:0] : '0;
                exec_res.code_length = enc_len;
                exec_res.too_long    = (enc_len > LEN_W'(CODE_W));
            end
            FUNC_DECODE:
            begin
                // A node number below the symbol count is a leaf.
                if (built_reg && (dec_next < NODE_W'(SYMBOL_COUNT)))
                begin
                    exec_has_res    = 1'b1;
                    exec_res.kind   = KIND_SYMBOL;
                    exec_res.symbol = dec_next[SYM_W-1:0];
                end
            end
            default:
            begin
                exec_has_res = 1'b0;
            end
        endcase
        build_res      = '0;
        build_res.kind = KIND_BUILD;
    end

    // Code bit for the edge just climbed: set when the child is the parent's one branch.
    // Bits are gathered leaf first, so the root edge ends up most significant.
    always_comb
    begin
        edge_idx = k_reg - LEN_W'(1);
        code_upd = code_reg;
        if ((k_reg != '0) && (edge_idx < LEN_W'(CODE_W)) && (link_rd_data.one == prev_reg))
        begin
            code_upd[edge_idx[CODE_IDX_W-1:0]] = 1'b1;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            T_IDLE:
            begin
                if (accept)
                begin
                    state_next = (item.func == FUNC_BUILD) ? B_HIST_RD : T_EXEC;
                end
            end
            T_EXEC:
            begin
                state_next = (exec_has_res && !slot_free) ? T_HOLD : T_IDLE;
            end
            T_HOLD:
            begin
                if (slot_free)
                begin
                    state_next = T_IDLE;
                end
            end
            B_HIST_RD:  state_next = B_HIST_INS;
            B_HIST_INS: state_next = B_INS_WAIT;
            B_INS_WAIT:
            begin
                if (lst_rsp.done)
                begin
                    state_next = (s_reg == LAST_SYM) ? B_POP : B_HIST_RD;
                end
            end
            B_POP:      state_next = B_POP_WAIT;
            B_POP_WAIT:
            begin
                if (lst_rsp.done)
                begin
                    state_next = B_LINK;
                end
            end
            B_LINK:     state_next = B_LINK2;
            B_LINK2:    state_next = B_MRG_WAIT;
            B_MRG_WAIT:
            begin
                if (lst_rsp.done)
                begin
                    state_next = lst_rsp.multi ? B_POP : W_START;
                end
            end
            W_START:    state_next = W_STEP;
            W_STEP:
            begin
                if (node_reg == ROOT_NODE)
                begin
                    state_next = (s_reg == LAST_SYM) ? B_DONE : W_START;
                end
            end
            B_DONE:
            begin
                state_next = slot_free ? T_IDLE : T_HOLD;
            end
            default:    state_next = T_IDLE;
        endcase
    end

    // Datapath and memory controls.
    always_comb
    begin
        hist_vld_next  = hist_vld_reg;
        built_next     = built_reg;
        pos_next       = pos_reg;
        res_valid_next = res_valid_reg && result_stall;
        res_next       = res_reg;
        pend_next      = pend_reg;
        in_next        = in_reg;
        s_next         = s_reg;
        next_next      = next_reg;
        node_next      = node_reg;
        prev_next      = prev_reg;
        k_next         = k_reg;
        code_next      = code_reg;

        hist_rd_en     = 1'b0;
        hist_rd_addr   = s_reg;
        hist_wr_en     = 1'b0;
        hist_wr_addr   = in_reg.data_byte;
        hist_wr_data   = hist_cur + COUNT_W'(1);
        code_rd_en     = 1'b0;
        code_rd_addr   = item.data_byte;
        code_wr_en     = 1'b0;
        code_wr_addr   = s_reg;
        code_wr_data   = {k_reg, code_upd};
        link_rd_en     = 1'b0;
        link_rd_addr   = node_reg;
        link_wr_en     = 1'b0;
        link_wr_addr   = next_reg;
        link_wr_data   = '{one: lst_rsp.first.node, zero: lst_rsp.second.node};
        up_rd_en       = 1'b0;
        up_rd_addr     = node_reg;
        up_wr_en       = 1'b0;
        up_wr_addr     = lst_rsp.first.node;
        up_wr_data     = next_reg;

        lst_req        = '0;

        case (state_reg)
            T_IDLE:
            begin
                if (accept)
                begin
                    in_next      = item;
                    hist_rd_en   = 1'b1;
                    hist_rd_addr = item.data_byte;
                    code_rd_en   = 1'b1;
                    code_rd_addr = item.data_byte;
                    link_rd_en   = 1'b1;
                    link_rd_addr = pos_reg;
                    s_next       = '0;
                    lst_req.clear = (item.func == FUNC_BUILD);
                end
            end
            T_EXEC:
            begin
                if ((in_reg.func == FUNC_COUNT) && (hist_cur != COUNT_MAX))
                begin
                    hist_wr_en                     = 1'b1;
                    hist_vld_next[in_reg.data_byte] = 1'b1;
                end
                if ((in_reg.func == FUNC_DECODE) && built_reg)
                begin
                    pos_next = exec_has_res ? ROOT_NODE : dec_next;
                end
                if (exec_has_res)
                begin
                    if (slot_free)
                    begin
                        res_valid_next = 1'b1;
                        res_next       = exec_res;
                    end
                    else
                    begin
                        pend_next = exec_res;
                    end
                end
            end
            T_HOLD:
            begin
                if (slot_free)
                begin
                    res_valid_next = 1'b1;
                    res_next       = pend_reg;
                end
            end
            B_HIST_RD:
            begin
                hist_rd_en   = 1'b1;
                hist_rd_addr = s_reg;
            end
            B_HIST_INS:
            begin
                lst_req.insert       = 1'b1;
                lst_req.entry.node   = NODE_W'(s_reg);
                lst_req.entry.weight = hist_vld_reg[s_reg] ? WEIGHT_W'(hist_rd_data) : '0;
            end
            B_INS_WAIT:
            begin
                if (lst_rsp.done)
                begin
                    s_next    = s_reg + SYM_W'(1);
                    next_next = NODE_W'(SYMBOL_COUNT);
                end
            end
            B_POP:
            begin
                lst_req.pop = 1'b1;
            end
            B_LINK:
            begin
                link_wr_en = 1'b1;
                up_wr_en   = 1'b1;
            end
            B_LINK2:
            begin
                up_wr_en             = 1'b1;
                up_wr_addr           = lst_rsp.second.node;
                lst_req.insert       = 1'b1;
                lst_req.entry.node   = next_reg;
                lst_req.entry.weight = lst_rsp.first.weight + lst_rsp.second.weight;
            end
            B_MRG_WAIT:
            begin
                if (lst_rsp.done)
                begin
                    next_next = next_reg + NODE_W'(1);
                    s_next    = '0;
                end
            end
            W_START:
            begin
                link_rd_en   = 1'b1;
                link_rd_addr = NODE_W'(s_reg);
                up_rd_en     = 1'b1;
                up_rd_addr   = NODE_W'(s_reg);
                node_next    = NODE_W'(s_reg);
                prev_next    = NODE_W'(s_reg);
                k_next       = '0;
                code_next    = '0;
            end
            W_STEP:
            begin
                if (node_reg == ROOT_NODE)
                begin
                    code_wr_en = 1'b1;
                    s_next     = s_reg + SYM_W'(1);
                end
                else
                begin
                    link_rd_en   = 1'b1;
                    link_rd_addr = up_rd_data;
                    up_rd_en     = 1'b1;
                    up_rd_addr   = up_rd_data;
                    prev_next    = node_reg;
                    node_next    = up_rd_data;
                    k_next       = k_reg + LEN_W'(1);
                    code_next    = code_upd;
                end
            end
            B_DONE:
            begin
                built_next    = 1'b1;
                pos_next      = ROOT_NODE;
                hist_vld_next = '0;
                if (slot_free)
                begin
                    res_valid_next = 1'b1;
                    res_next       = build_res;
                end
                else
                begin
                    pend_next = build_res;
                end
            end
            default:
            begin
                lst_req = '0;
            end
        endcase
    end

endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for the byte-alphabet Huffman codec.
// Stimulus is driven transaction by transaction through plain tasks. A small scoreboard
// class keeps its own copy of the histogram, the tree, the code table and the decode
// position, and it predicts the result of every accepted transaction. Each round fills a
// histogram (round 2 keeps stray counts only), builds the table, then mixes encodes,
// well-formed decode bit sequences, random decode bits and counts for the next round.
module tb_top;
    import bhc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 1000000;  // cycles without any transaction
    localparam int ITEM_GOAL   = 1950;
    localparam int ROOT        = NODE_SLOTS - 2;

    // Scoreboard: Huffman predictor plus the queue of expected results.
    class huffman_scoreboard;
        int unsigned hist[SYMBOL_COUNT];
        longint      weight[NODE_SLOTS];
        int          link_one[NODE_SLOTS];
        int          link_zero[NODE_SLOTS];
        int          link_up[NODE_SLOTS];
        logic [NODE_SLOTS-1:0] path_bits[SYMBOL_COUNT];
        int          code_len[SYMBOL_COUNT];
        int          dec_pos;
        bit          built;
        int          sorted[$];
        result_t     expected_results[$];
        int          mismatches;

        function void clear_state();
            for (int i = 0; i < NODE_SLOTS; i++)
            begin
                weight[i] = 0;
                link_one[i] = 0;
                link_zero[i] = 0;
                link_up[i] = 0;
            end
            for (int s = 0; s < SYMBOL_COUNT; s++)
            begin
                hist[s] = 0;
                path_bits[s] = '0;
                code_len[s] = 0;
            end
            dec_pos = ROOT;
            built = 0;
            mismatches = 0;
        endfunction

        // A node never goes ahead of an equal head; otherwise it lands before the
        // first later entry whose weight is at least its own.
        function void sorted_insert(int node);
            int pos;
            longint w;
            w = weight[node];
            if (sorted.size() == 0 || w < weight[sorted[0]])
                pos = 0;
            else
            begin
                pos = 1;
                while (pos < sorted.size() && w > weight[sorted[pos]])
                    pos++;
            end
            sorted.insert(pos, node);
        endfunction

        function void build_table();
            int next_node;
            int a;
            int b;
            int node;
            int k;
            int up;
            sorted.delete();
            for (int s = 0; s < SYMBOL_COUNT; s++)
            begin
                weight[s] = hist[s];
                link_one[s] = 0;
                link_zero[s] = 0;
                link_up[s] = 0;
                sorted_insert(s);
            end
            next_node = SYMBOL_COUNT;
            while (sorted.size() > 1)
            begin
                a = sorted.pop_front();
                b = sorted.pop_front();
                weight[next_node] = weight[a] + weight[b];
                link_one[next_node] = a;
                link_zero[next_node] = b;
                link_up[next_node] = 0;
                link_up[a] = next_node;
                link_up[b] = next_node;
                sorted_insert(next_node);
                next_node++;
            end
            // Walk every leaf up to the root; bit k is the branch taken k levels up.
            for (int s = 0; s < SYMBOL_COUNT; s++)
            begin
                node = s;
                k = 0;
                path_bits[s] = '0;
                while (node != ROOT && k < NODE_SLOTS)
                begin
                    up = link_up[node];
                    if (link_one[up] == node)
                        path_bits[s][k] = 1'b1;
                    k++;
                    node = up;
                end
                code_len[s] = k;
            end
            foreach (hist[s])
                hist[s] = 0;
            dec_pos = ROOT;
            built = 1;
        endfunction

        // Called for every accepted input transaction.
        function void note_item(item_t it);
            result_t r;
            r = '0;
            case (it.func)
                FUNC_COUNT:
                    if (hist[it.data_byte] < COUNT_MAX)
                        hist[it.data_byte]++;
                FUNC_BUILD:
                begin
                    build_table();
                    r.kind = KIND_BUILD;
                    expected_results.push_back(r);
                end
                FUNC_ENCODE:
                begin
                    r.kind = KIND_CODE;
                    r.code_word = path_bits[it.data_byte][CODE_W-1:0];
                    r.code_length = LEN_W'(code_len[it.data_byte]);
                    r.too_long = (code_len[it.data_byte] > CODE_W);
                    expected_results.push_back(r);
                end
                default:
                    if (built)
                    begin
                        dec_pos = it.code_bit ? link_one[dec_pos] : link_zero[dec_pos];
                        if (dec_pos < SYMBOL_COUNT)
                        begin
                            r.kind = KIND_SYMBOL;
                            r.symbol = SYM_W'(dec_pos);
                            dec_pos = ROOT;
                            expected_results.push_back(r);
                        end
                    end
            endcase
        endfunction

        // Called for every accepted result transaction.
        function void check_result(result_t got);
            result_t want;
            if (expected_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected result %p", got);
                return;
            end
            want = expected_results.pop_front();
            if (got.kind != want.kind || got.code_word != want.code_word ||
                got.code_length != want.code_length || got.symbol != want.symbol ||
                got.too_long != want.too_long)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: result mismatch, expected %p, actual %p", want, got);
            end
        endfunction
    endclass

    logic    clk;
    logic    rst_n;
    logic    item_valid;
    logic    item_stall;
    item_t   item;
    logic    result_valid;
    logic    result_stall;
    result_t result;

    huffman_scoreboard sb;
    int      sender_idle_pct;
    int      receiver_stall_pct;
    int      items_sent;
    int      quiet_cycles = 0;

    byte_huffman_codec i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // The result monitor samples at the rising edge, where the values seen are the ones
    // that were present before the edge. Input transactions are noted by the driver at
    // the edge where they are accepted, so the predictor is current when it returns.
    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
            sb.check_result(result);
    end

    // The receiver stalls at random according to the current phase.
    always @(posedge clk)
    begin
        if (!rst_n)
            result_stall <= 1'b0;
        else
            result_stall <= ($urandom_range(99) < receiver_stall_pct);
    end

    // Watchdog: a build may keep the block busy for a long stretch, so the limit is
    // generous, but a run in which nothing moves at all ends here as a failure.
    always @(posedge clk)
    begin
        if ((item_valid && !item_stall) || (result_valid && !result_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Drives one input transaction and returns at the edge where it is accepted.
    // An idle gap lowers valid first; otherwise valid stays high back to back.
    task automatic send_item(logic [1:0] func, logic [SYM_W-1:0] data, logic bit_in);
        item_t it;
        int gap;
        it.func = func;
        it.data_byte = data;
        it.code_bit = bit_in;
        if ($urandom_range(99) < sender_idle_pct)
        begin
            gap = $urandom_range(1, 4);
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        item <= it;
        do
            @(posedge clk);
        while (item_stall);
        sb.note_item(it);
        items_sent++;
    endtask

    // Waits until every expected result has arrived, such as after a build.
    task automatic drain_results();
        item_valid <= 1'b0;
        @(posedge clk);
        while (sb.expected_results.size() != 0)
            @(posedge clk);
    endtask

    // Sends the full code of one symbol, root bit first, so that the decoder walks
    // the tree to that leaf. Stray bits left by noise are first flushed to a leaf.
    task automatic decode_symbol(int sym);
        while (sb.dec_pos != ROOT)
            send_item(FUNC_DECODE, '0, 1'($urandom_range(1)));
        for (int k = sb.code_len[sym] - 1; k >= 0; k--)
            send_item(FUNC_DECODE, SYM_W'($urandom), sb.path_bits[sym][k]);
    endtask

    task automatic set_phase(int mode);
        case (mode % 4)
            0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
            1: begin sender_idle_pct = 55; receiver_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  receiver_stall_pct = 55; end
            default: begin sender_idle_pct = 29; receiver_stall_pct = 29; end
        endcase
    endtask

    initial
    begin
        int sym;
        int pick;
        int tries;
        int hot;

        sb = new();
        sb.clear_state();
        rst_n = 1'b0;
        item_valid = 1'b0;
        item = '0;
        items_sent = 0;
        set_phase(0);
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: decode and encode before any build, the byte extremes,
        // a tiny histogram, then encodes and decode bits on the new table.
        send_item(FUNC_DECODE, 8'h00, 1'b1);
        send_item(FUNC_DECODE, 8'hFF, 1'b0);
        send_item(FUNC_ENCODE, 8'h00, 1'b0);
        send_item(FUNC_ENCODE, 8'hFF, 1'b1);
        send_item(FUNC_COUNT, 8'h00, 1'b0);
        send_item(FUNC_COUNT, 8'hFF, 1'b1);
        send_item(FUNC_COUNT, 8'hFF, 1'b0);
        send_item(FUNC_COUNT, 8'hAA, 1'b0);
        send_item(FUNC_COUNT, 8'h55, 1'b1);
        send_item(FUNC_BUILD, 8'h00, 1'b0);
        drain_results();
        send_item(FUNC_ENCODE, 8'h00, 1'b0);
        send_item(FUNC_ENCODE, 8'hFF, 1'b0);
        send_item(FUNC_ENCODE, 8'h01, 1'b1);
        send_item(FUNC_ENCODE, 8'h80, 1'b0);
        decode_symbol(8'hFF);
        decode_symbol(8'h00);
        send_item(FUNC_DECODE, 8'h00, 1'b1);
        send_item(FUNC_DECODE, 8'h00, 1'b0);
        send_item(FUNC_DECODE, 8'h00, 1'b1);

        // One long count run with no idling, so a single byte outweighs all.
        for (int i = 0; i < 200; i++)
            send_item(FUNC_COUNT, 8'h5A, 1'($urandom_range(1)));
        send_item(FUNC_BUILD, 8'h00, 1'b0);
        drain_results();
        send_item(FUNC_ENCODE, 8'h5A, 1'b0);
        decode_symbol(8'h5A);

        // Random rounds: most fill a histogram of a different shape; each builds, then
        // mixes encodes, well-formed decodes, stray decode bits and counts.
        for (int round = 0; round < 7 && items_sent < ITEM_GOAL; round++)
        begin
            set_phase(round);
            hot = $urandom_range(1, 12);
            if (round != 2)  // round 2 builds over the stray counts of round 1 only
            begin
                for (int i = 0; i < 90; i++)
                begin
                    if (round % 2)
                        sym = $urandom_range(hot);
                    else
                        sym = $urandom_range(255);
                    send_item(FUNC_COUNT, SYM_W'(sym), 1'($urandom_range(1)));
                end
            end
            send_item(FUNC_BUILD, SYM_W'($urandom), 1'($urandom_range(1)));
            drain_results();
            for (int i = 0; i < 180 && items_sent < (ITEM_GOAL * (round + 1)) / 7; i++)
            begin
                pick = $urandom_range(99);
                if (pick < 55)
                begin
                    // Prefer symbols with short codes so the decode traffic is dense.
                    tries = 0;
                    do
                    begin
                        sym = (round % 2) ? $urandom_range(hot) : $urandom_range(255);
                        tries++;
                    end
                    while (sb.code_len[sym] > 24 && tries < 20);
                    if (sb.code_len[sym] <= 24)
                        decode_symbol(sym);
                    else
                        send_item(FUNC_DECODE, SYM_W'($urandom), 1'($urandom_range(1)));
                end
                else if (pick < 80)
                    send_item(FUNC_ENCODE, SYM_W'($urandom), 1'($urandom_range(1)));
                else if (pick < 90)
                    send_item(FUNC_DECODE, SYM_W'($urandom), 1'($urandom_range(1)));
                else
                    send_item(FUNC_COUNT, SYM_W'($urandom), 1'($urandom_range(1)));
            end
        end

        // Count and decode transactions may still be in flight without a result.
        drain_results();
        repeat (50) @(posedge clk);
        if (sb.mismatches == 0 && sb.expected_results.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule
